// ===== hw/rtl/psort_pkg.sv =====
package psort_pkg;

  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned PayloadW      = 64;
  localparam int unsigned SortCountW    = 7;
  localparam int unsigned RecW          = KeyW + PayloadW;

  // one stored record, key in the low half
  typedef struct packed {
    logic [PayloadW-1:0]    payload;
    logic signed [KeyW-1:0] key;
  } rec_t;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic ins_en;     // place the incoming record this cycle
    logic sort_mode;  // incoming record goes into the ordered prefix
    logic drain;      // advance every cell toward cell 0
  } ctl_t;

endpackage

// ===== hw/rtl/psort_cell.sv =====
module psort_cell #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  psort_pkg::ctl_t  ctl_i,
  input  logic [CNT_W-1:0] count_i,
  input  psort_pkg::rec_t  new_rec_i,
  input  psort_pkg::rec_t  left_rec_i,
  input  psort_pkg::rec_t  right_rec_i,
  input  logic             left_mark_i,
  input  logic             left_pass_i,
  output psort_pkg::rec_t  rec_o,
  output logic             mark_o,
  output logic             pass_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  psort_pkg::rec_t rec_q, rec_d;
  logic            occ, gt, take_new;

  // occupied cells form a prefix of the chain
  assign occ      = MyIdx < count_i;
  assign gt       = $signed(rec_q.key) > $signed(new_rec_i.key);
  // mark: new record belongs here or further left
  assign mark_o   = !occ || (ctl_i.sort_mode && gt);
  assign pass_o   = mark_o && occ;
  assign take_new = ctl_i.ins_en && mark_o && !left_mark_i;

  always_comb begin
    rec_d = rec_q;
    priority if (ctl_i.drain) begin
      rec_d = right_rec_i;
    end else if (ctl_i.ins_en && left_pass_i) begin
      rec_d = left_rec_i;
    end else if (take_new) begin
      rec_d = new_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== hw/rtl/psort_ctrl.sv =====
module psort_ctrl #(
  parameter int unsigned MAX_RECORDS = psort_pkg::MaxRecordsDef,
  parameter int unsigned CNT_W       = $clog2(MAX_RECORDS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psort_pkg::SortCountW-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_last_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_last_o,
  output logic                             overflow_o,
  output psort_pkg::ctl_t                  ctl_o,
  output logic [CNT_W-1:0]                 count_o
);

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  state_e                             state_q;
  logic [CNT_W-1:0]                   count_q;
  logic                               ovf_q;
  logic [psort_pkg::SortCountW-1:0]   sort_count_q;
  logic                               in_acc, out_acc, room;

  assign in_ready_o  = state_q == ST_COLLECT;
  assign out_valid_o = state_q == ST_DRAIN;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign room        = count_q < CntMax;

  assign ctl_o.ins_en    = in_acc && room;
  assign ctl_o.sort_mode = psort_pkg::SortCountW'(count_q) < sort_count_q;
  assign ctl_o.drain     = out_acc;

  assign count_o    = count_q;
  assign out_last_o = count_q == CntOne;
  assign overflow_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_COLLECT;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      sort_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        sort_count_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_COLLECT: begin
          if (in_acc) begin
            if (room) begin
              count_q <= count_q + CntOne;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_last_i) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            count_q <= count_q - CntOne;
            if (count_q == CntOne) begin
              state_q <= ST_COLLECT;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/prefix_insertion_sorter.sv =====
// Prefix insertion sorter.
// Input stream (s_axis_*): one record per request, tdata = {payload, key} with the
// signed 64-bit key in bits 63:0; tlast marks the final record of a batch.
// Output stream (m_axis_*): the batch comes back with the first sort_count records
// in ascending key order (equal keys keep arrival order), then the rest in arrival
// order. tlast flags the final record, tuser[0] flags a batch that overflowed the
// store of MAX_RECORDS entries (extra records are dropped, the last still ends it).
// Configuration: cfg_we_i writes sort_count; write it only between batches.
// Throughput: one record per cycle while collecting; each record is placed into a
// chain of MAX_RECORDS cells in the cycle it arrives, all cells comparing at once.
// Latency: the first result is shown the cycle after the last record is taken;
// the batch then leaves at one record per cycle while m_axis_tready_i is high,
// as the chain advances toward cell 0. Input is held off (s_axis_tready_o low)
// for the whole drain.
// Stall: while m_axis_tready_i is low, the chain and the shown result hold.
// Reset: empties the batch, clears the overflow flag and sets sort_count to 0;
// cell contents are not cleared and are never shown before being written.
module prefix_insertion_sorter #(
  parameter int unsigned MAX_RECORDS = psort_pkg::MaxRecordsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psort_pkg::SortCountW-1:0] cfg_wdata_i,     // sort_count
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [psort_pkg::RecW-1:0]       s_axis_tdata_i,  // record_key, record_payload
  input  logic                             s_axis_tlast_i,  // last_record
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [psort_pkg::RecW-1:0]       m_axis_tdata_o,  // out_key, out_payload
  output logic                             m_axis_tlast_o,  // out_last
  output logic                             m_axis_tuser_o   // overflow
);

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  psort_pkg::ctl_t  ctl;
  logic [CntW-1:0]  count;
  psort_pkg::rec_t  new_rec;
  psort_pkg::rec_t  rec   [MAX_RECORDS];
  logic             mark  [MAX_RECORDS+1];
  logic             pass  [MAX_RECORDS+1];

  assign new_rec = psort_pkg::rec_t'(s_axis_tdata_i);

  // Sequencer: batch count, overflow flag, sort_count register, handshakes.
  psort_ctrl #(
    .MAX_RECORDS (MAX_RECORDS),
    .CNT_W       (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .overflow_o  (m_axis_tuser_o),
    .ctl_o       (ctl),
    .count_o     (count)
  );

  // Nothing lies left of cell 0.
  assign mark[0] = 1'b0;
  assign pass[0] = 1'b0;

  // Cell chain: sorted inserts push larger keys one cell right, others append;
  // drain pulls every record one cell left so cell 0 always holds the next result.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    psort_pkg::rec_t left_rec, right_rec;

    if (i == 0) begin : g_first
      assign left_rec = new_rec;
    end else begin : g_mid
      assign left_rec = rec[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = rec[i];
    end else begin : g_body
      assign right_rec = rec[i+1];
    end

    psort_cell #(
      .CNT_W (CntW),
      .IDX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count),
      .new_rec_i   (new_rec),
      .left_rec_i  (left_rec),
      .right_rec_i (right_rec),
      .left_mark_i (mark[i]),
      .left_pass_i (pass[i]),
      .rec_o       (rec[i]),
      .mark_o      (mark[i+1]),
      .pass_o      (pass[i+1])
    );
  end

  // Result comes straight from cell 0's register.
  assign m_axis_tdata_o = rec[0];

endmodule

// ===== hw/rtl/psort_chk.sv =====
module psort_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             s_axis_tlast_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [psort_pkg::RecW-1:0]       m_axis_tdata_o,
  input logic                             m_axis_tlast_o,
  input logic                             m_axis_tuser_o
);

  // Collecting and draining never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while results pending");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // The final input request starts emission in the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("emission did not start after last record");

  // The final result returns the block to collecting; others keep draining.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=>
      (m_axis_tvalid_o != $past(m_axis_tlast_o)) && (s_axis_tready_o == $past(m_axis_tlast_o)))
    else $error("drain did not end on the last result");

endmodule

bind prefix_insertion_sorter psort_chk u_psort_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_RECORDS   = psort_pkg::MaxRecordsDef;
  localparam int unsigned SortCountW    = psort_pkg::SortCountW;
  localparam int unsigned RecW          = psort_pkg::RecW;
  localparam int          NO_CFG        = -1;
  localparam int unsigned RANDOM_ITEMS  = 180;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  typedef psort_pkg::rec_t rec_t;

  // one emitted record as the output stream carries it
  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } emitted_t;

  // directed stimulus: reps records with key counting down and payload counting up;
  // pinned rows are single-record batches whose result is typed in
  typedef struct {
    int          cfg;
    logic [63:0] key;
    logic [63:0] payload;
    bit          last;
    int          reps;
    bit          pinned;
    logic [63:0] exp_key;
    logic [63:0] exp_payload;
    bit          exp_last;
    bit          exp_ovf;
  } stim_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [SortCountW-1:0] cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [RecW-1:0]       s_axis_tdata_i  = '0;
  logic                  s_axis_tlast_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [RecW-1:0]       m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;

  prefix_insertion_sorter #(
    .MAX_RECORDS(MAX_RECORDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  rec_t                  batch_recs[$];
  bit                    batch_ovf;
  logic [SortCountW-1:0] model_sort_count = '0;
  emitted_t              sorted_results[$];

  // pinned expectation that travels with the request being driven
  bit       pin_now;
  emitted_t pin_result;

  bit          gaps_off;
  int unsigned mismatch_count, cycle_count;
  int unsigned records_in, results_out, batches_done, overflow_batches, cfg_writes;
  int unsigned random_items;

  stim_row_t directed_rows [20] = '{
    // after reset: sort_count is 0, a lone record comes straight back (also at 64)
    '{NO_CFG, 64'h0, 64'h0, 1, 1, 1, 64'h0, 64'h0, 1, 0},
    '{NO_CFG, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1,
      64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0},
    '{NO_CFG, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 1, 1, 1,
      64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 1, 0},
    '{64, 64'd42, 64'hAAAA_AAAA_AAAA_AAAA, 1, 1, 1,
      64'd42, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0},
    // full sort of key extremes with duplicate keys; sort_count beyond batch
    '{NO_CFG, 64'd5, 64'd1, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'h8000_0000_0000_0000, 64'd4, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'd5, 64'd5, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'hFFFF_FFFF_FFFF_FFFF, 64'd6, 1, 1, 0, 0, 0, 0, 0},
    // sort_count one, then zero: arrival order is kept
    '{1, 64'd9, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'd3, 64'd7, 0, 1, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'hFFFF_FFFF_FFFF_FFF9, 64'd8, 1, 1, 0, 0, 0, 0, 0},
    '{0, 64'd100, 64'd9, 0, 3, 0, 0, 0, 0, 0},
    '{NO_CFG, 64'hFFFF_FFFF_FFFF_FFF7, 64'd10, 1, 1, 0, 0, 0, 0, 0},
    // prefix shorter than the batch
    '{3, 64'd40, 64'd20, 1, 6, 0, 0, 0, 0, 0},
    // store exactly full, descending keys
    '{64, 64'd1000, 64'h100, 1, MAX_RECORDS, 0, 0, 0, 0, 0},
    // overflow: the marked record itself is dropped
    '{10, 64'd500, 64'h200, 1, MAX_RECORDS + 6, 0, 0, 0, 0, 0},
    '{63, 64'h0, 64'h300, 1, MAX_RECORDS + 2, 0, 0, 0, 0, 0},
    // first record after overflow starts a clean batch
    '{2, 64'd7, 64'h400, 1, 2, 0, 0, 0, 0, 0}
  };

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // store one request; on the marked one, sort the prefix and queue the batch
  task automatic take_record(input rec_t rec, input bit last);
    rec_t        held;
    emitted_t    res;
    int unsigned n, k, j;
    records_in++;
    if (batch_recs.size() < MAX_RECORDS) batch_recs.push_back(rec);
    else batch_ovf = 1'b1;
    if (last) begin
      n = batch_recs.size();
      k = (model_sort_count < n) ? model_sort_count : n;
      for (int unsigned i = 1; i < k; i++) begin
        held = batch_recs[i];
        j = i;
        while (j > 0 && $signed(batch_recs[j-1].key) > $signed(held.key)) begin
          batch_recs[j] = batch_recs[j-1];
          j--;
        end
        batch_recs[j] = held;
      end
      if (pin_now) begin
        sorted_results.push_back(pin_result);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          res.rec  = batch_recs[i];
          res.last = (i + 1 == n);
          res.ovf  = batch_ovf;
          sorted_results.push_back(res);
        end
      end
      batches_done++;
      if (batch_ovf) overflow_batches++;
      batch_recs.delete();
      batch_ovf = 1'b0;
    end
  endtask

  task automatic check_result(input emitted_t got);
    emitted_t want;
    results_out++;
    if (sorted_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result key %h payload %h",
                                got.rec.key, got.rec.payload));
    end else begin
      want = sorted_results.pop_front();
      if (got.rec.key !== want.rec.key)
        report_mismatch($sformatf("result %0d key %h, want %h",
                                  results_out, got.rec.key, want.rec.key));
      if (got.rec.payload !== want.rec.payload)
        report_mismatch($sformatf("result %0d payload %h, want %h",
                                  results_out, got.rec.payload, want.rec.payload));
      if (got.last !== want.last)
        report_mismatch($sformatf("result %0d tlast %b, want %b",
                                  results_out, got.last, want.last));
      if (got.ovf !== want.ovf)
        report_mismatch($sformatf("result %0d overflow %b, want %b",
                                  results_out, got.ovf, want.ovf));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end else begin
        if (cfg_we_i) model_sort_count = cfg_wdata_i;
        if (s_axis_tvalid_i && s_axis_tready_o)
          take_record(rec_t'(s_axis_tdata_i), s_axis_tlast_i);
        if (m_axis_tvalid_o && m_axis_tready_i)
          check_result(emitted_t'{rec: rec_t'(m_axis_tdata_o), last: m_axis_tlast_o,
                                  ovf: m_axis_tuser_o});
      end
    end
  end

  // output backpressure: mostly ready, stalls of random length
  initial begin
    int unsigned span;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 7) begin
        m_axis_tready_i = 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
      end else begin
        m_axis_tready_i = 1'b0;
        span = idle_len();
      end
      repeat (span) @(negedge clk_i);
    end
  end

  task automatic push_record(input logic [63:0] key, input logic [63:0] payload,
                             input bit last, input bit pinned, input emitted_t pinned_res);
    int unsigned gap;
    gap = gaps_off ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {payload, key};
    s_axis_tlast_i  = last;
    pin_now         = pinned;
    pin_result      = pinned_res;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  // hold input until every queued result has left, then let the block settle
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (sorted_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_sort_count(input logic [SortCountW-1:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = SortCountW'($urandom_range(0, 127));
  endtask

  function automatic logic [SortCountW-1:0] pick_sort_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return SortCountW'(1);
    if (r < 40) return SortCountW'(MAX_RECORDS);
    return SortCountW'($urandom_range(2, MAX_RECORDS - 1));
  endfunction

  function automatic int unsigned pick_batch_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, MAX_RECORDS);
    return $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
  endfunction

  // wide random keys, a narrow range full of ties, or the corners
  function automatic logic [63:0] make_key(input int unsigned mode);
    logic signed [63:0] v;
    case (mode)
      0: v = {$urandom, $urandom};
      1: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 64'h7FFF_FFFF_FFFF_FFFF;
          1: v = 64'h8000_0000_0000_0000;
          2: v = '1;
          3: v = 64'd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned batch_len, key_mode, r;
    stim_row_t   row;
    emitted_t    pinned_res;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[idx]) begin
      row = directed_rows[idx];
      if (row.cfg != NO_CFG) write_sort_count(SortCountW'(row.cfg));
      pinned_res = '{rec: '{payload: row.exp_payload, key: row.exp_key},
                     last: row.exp_last, ovf: row.exp_ovf};
      for (int i = 0; i < row.reps; i++)
        push_record(row.key - 64'(i), row.payload + 64'(i),
                    row.last && (i == row.reps - 1), row.pinned, pinned_res);
    end

    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 4) write_sort_count(pick_sort_count());
      else if (r == 4) wait_drained();
      gaps_off  = ($urandom_range(0, 3) == 0);
      batch_len = pick_batch_len();
      key_mode  = $urandom_range(0, 2);
      for (int unsigned i = 0; i < batch_len; i++)
        push_record(make_key(key_mode), {$urandom, $urandom}, i + 1 == batch_len, 1'b0, '0);
      random_items += batch_len;
    end
    gaps_off = 1'b0;

    wait_drained();
    repeat (16) @(negedge clk_i);
    if (sorted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_results.size()));

    $display("covered %0d batches (%0d overflowed) over %0d sort_count writes",
             batches_done, overflow_batches, cfg_writes);
    $display("%0d records sent, %0d records checked, %0d mismatches",
             records_in, results_out, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/psort_pkg.sv
hw/rtl/psort_cell.sv
hw/rtl/psort_ctrl.sv
hw/rtl/prefix_insertion_sorter.sv
hw/rtl/psort_chk.sv
tb/tb.sv
